// ===== sv/ksyf_pkg.sv =====
// shared types, constants and saturation helpers for the speed/yaw filter
`default_nettype none

package ksyf_pkg;

   localparam int WORD_W        = 32;
   localparam int CSR_W         = 17;
   localparam int CSR_IDX_W     = 3;
   localparam int DT_W          = 20;
   localparam int OPD_W         = 33;
   localparam int PROD_FULL_W   = 2 * OPD_W;
   localparam int UVAL_W        = 31;
   localparam int PROD_W        = 2 * UVAL_W;
   localparam int DET_W         = 3 * UVAL_W;
   localparam int QUOT_W        = 31;
   localparam int FRAC_BITS_DEF = 16;

   localparam logic [WORD_W-1:0] VAR_RESET        = 32'd65536;
   localparam logic [CSR_W-1:0]  PROC_NOISE_RESET = 17'd6;
   localparam logic [CSR_W-1:0]  MEAS_NOISE_RESET = 17'd655;

   localparam logic [CSR_IDX_W-1:0] CSR_PROC_SPEED = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROC_YAW   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAS_SPEED = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAS_YAW   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAS_GYRO  = 3'd4;

   localparam logic OP_PREDICT = 1'b0;
   localparam logic OP_UPDATE  = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic signed [31:0] accel;
      logic signed [31:0] gyro_rate;
      logic [DT_W-1:0]    time_step;
      logic signed [31:0] enc_speed;
      logic signed [31:0] enc_yaw_rate;
   } req_data_type;

   typedef struct packed {
      logic signed [31:0] pos_x_out;
      logic signed [31:0] heading_out;
      logic signed [31:0] speed_out;
      logic signed [31:0] yaw_rate_out;
      logic               singular;
   } rsp_data_type;

   function automatic logic signed [31:0] sat34(input logic signed [33:0] x);
      logic signed [31:0] r;
      if (!x[33] && (x[32] || x[31])) begin
         r = 32'sh7FFFFFFF;
      end else if (x[33] && !(x[32] && x[31])) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat66(input logic signed [65:0] x);
      logic signed [31:0] r;
      if (!x[65] && (|x[64:31])) begin
         r = 32'sh7FFFFFFF;
      end else if (x[65] && !(&x[64:31])) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] add_sat(input logic signed [31:0] x,
                                                  input logic signed [31:0] y);
      return sat34({{2{x[31]}}, x} + {{2{y[31]}}, y});
   endfunction

endpackage

`default_nettype wire

// ===== sv/ksyf_req_if.sv =====
// valid/ready channel interfaces for filter requests and results
`default_nettype none

interface ksyf_req_if import ksyf_pkg::*; ();
   logic         valid;
   logic         ready;
   req_data_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface ksyf_rsp_if import ksyf_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_data_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/kalman_speed_yaw_filter_core.sv =====
// top level: speed/yaw Kalman filter sequencer around a shared multiplier and divider
// predict: three multiply steps on the shared multiplier
// update: three runs of the bit-serial divider, each cut short if its quotient saturates
// update with singular covariance: divider skipped, singular flag set in the result
// one transaction at a time; a new request is taken while the last result waits
// synchronous active-high reset: state zero, variances one, noise registers to defaults
`default_nettype none

module kalman_speed_yaw_filter_core import ksyf_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   ksyf_req_if.sink             req_ch,
   ksyf_rsp_if.source           rsp_ch,
   input  wire                  csr_we,
   input  wire  [CSR_IDX_W-1:0] csr_index,
   input  wire  [CSR_W-1:0]     csr_wdata
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_P0, ST_P1, ST_P2, ST_P3,
      ST_U0, ST_U1, ST_U2, ST_U3, ST_U4, ST_U5, ST_U6, ST_U7, ST_U8,
      ST_DIV, ST_K0, ST_K1, ST_K2, ST_FIN
   } state_type;

   localparam logic [1:0] GAIN_SPEED = 2'd0;
   localparam logic [1:0] GAIN_YAW   = 2'd1;
   localparam logic [1:0] GAIN_GYRO  = 2'd2;

   state_type state_ff;
   logic [1:0] sel_ff;

   logic [CSR_W-1:0] proc_speed_ff, proc_yaw_ff, meas_speed_ff, meas_yaw_ff, meas_gyro_ff;
   logic signed [31:0] pos_x_ff, heading_ff, speed_ff, yaw_rate_ff, var_speed_ff, var_yaw_ff;

   req_data_type in_ff;
   rsp_data_type out_ff;
   logic         rsp_valid_ff;
   logic         sing_ff;

   logic signed [31:0] y0_ff, y1_ff, y2_ff, k_ff;
   logic [UVAL_W-1:0]  a_ff, b_ff, c_ff;
   logic [PROD_W-1:0]  bc_ff, cof_ff, ac_ff, ab_ff;
   logic [DET_W-1:0]   det_ff;

   logic signed [OPD_W-1:0]       mul_a, mul_b;
   logic signed [PROD_FULL_W-1:0] prod_ff;
   logic signed [PROD_FULL_W-1:0] prod_sh;
   logic signed [31:0]            qp;

   logic                         div_start;
   logic [PROD_W-1:0]            div_num;
   logic                         div_done;
   logic [QUOT_W-1:0]            div_quot;
   logic [DET_W-FRAC_BITS-1:0]   det_q;
   logic                         req_fire, rsp_fire;
   logic                         rsp_load;

   assign prod_sh = prod_ff >>> FRAC_BITS;
   assign qp      = sat66(prod_sh);
   assign det_q   = det_ff[DET_W-1:FRAC_BITS];

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = out_ff;
   assign rsp_fire     = rsp_valid_ff && rsp_ch.ready;
   // result register is free or being emptied this cycle
   assign rsp_load     = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ch.ready);

   ksyf_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod_ff)
   );

   ksyf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num     (div_num),
      .den     (det_q),
      .done_ff (div_done),
      .quot_ff (div_quot)
   );

   // operand selection for the shared multiplier and divider launch
   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      div_num   = cof_ff;
      case (state_ff)
         ST_P0: begin
            mul_a = {in_ff.accel[31], in_ff.accel};
            mul_b = OPD_W'(in_ff.time_step);
         end
         ST_P1: begin
            mul_a = {in_ff.gyro_rate[31], in_ff.gyro_rate};
            mul_b = OPD_W'(in_ff.time_step);
         end
         ST_P2: begin
            mul_a = {speed_ff[31], speed_ff};
            mul_b = OPD_W'(in_ff.time_step);
         end
         ST_U1: begin
            mul_a = OPD_W'(b_ff);
            mul_b = OPD_W'(c_ff);
         end
         ST_U2: begin
            mul_a = OPD_W'(var_yaw_ff[UVAL_W-1:0]);
            mul_b = OPD_W'(var_yaw_ff[UVAL_W-1:0]);
         end
         ST_U4: begin
            mul_a = OPD_W'(a_ff);
            mul_b = OPD_W'(cof_ff[UVAL_W-1:0]);
         end
         ST_U5: begin
            mul_a = OPD_W'(a_ff);
            mul_b = OPD_W'(cof_ff[PROD_W-1:UVAL_W]);
         end
         ST_U6: begin
            mul_a = OPD_W'(a_ff);
            mul_b = OPD_W'(c_ff);
         end
         ST_U7: begin
            mul_a = OPD_W'(a_ff);
            mul_b = OPD_W'(b_ff);
         end
         ST_U8: begin
            div_start = (det_q != '0);
            div_num   = cof_ff;
         end
         ST_DIV: begin
            mul_a = (sel_ff == GAIN_SPEED) ? {var_speed_ff[31], var_speed_ff}
                                           : {var_yaw_ff[31], var_yaw_ff};
            mul_b = OPD_W'(div_quot);
         end
         ST_K1: begin
            mul_a = {k_ff[31], k_ff};
            mul_b = (sel_ff == GAIN_SPEED) ? {y0_ff[31], y0_ff} :
                    (sel_ff == GAIN_YAW)   ? {y1_ff[31], y1_ff} : {y2_ff[31], y2_ff};
         end
         ST_K2: begin
            div_start = (sel_ff != GAIN_GYRO);
            div_num   = (sel_ff == GAIN_SPEED) ? ac_ff : ab_ff;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sel_ff        <= GAIN_SPEED;
         rsp_valid_ff  <= 1'b0;
         proc_speed_ff <= PROC_NOISE_RESET;
         proc_yaw_ff   <= PROC_NOISE_RESET;
         meas_speed_ff <= MEAS_NOISE_RESET;
         meas_yaw_ff   <= MEAS_NOISE_RESET;
         meas_gyro_ff  <= MEAS_NOISE_RESET;
         pos_x_ff      <= '0;
         heading_ff    <= '0;
         speed_ff      <= '0;
         yaw_rate_ff   <= '0;
         var_speed_ff  <= VAR_RESET;
         var_yaw_ff    <= VAR_RESET;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_PROC_SPEED: proc_speed_ff <= csr_wdata;
               CSR_PROC_YAW:   proc_yaw_ff   <= csr_wdata;
               CSR_MEAS_SPEED: meas_speed_ff <= csr_wdata;
               CSR_MEAS_YAW:   meas_yaw_ff   <= csr_wdata;
               CSR_MEAS_GYRO:  meas_gyro_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  in_ff    <= req_ch.data;
                  sing_ff  <= 1'b0;
                  state_ff <= (req_ch.data.opcode == OP_UPDATE) ? ST_U0 : ST_P0;
               end
            end
            ST_P0: state_ff <= ST_P1;
            ST_P1: begin
               speed_ff <= add_sat(speed_ff, qp);
               state_ff <= ST_P2;
            end
            ST_P2: begin
               heading_ff <= add_sat(heading_ff, qp);
               state_ff   <= ST_P3;
            end
            ST_P3: begin
               pos_x_ff     <= add_sat(pos_x_ff, qp);
               yaw_rate_ff  <= in_ff.gyro_rate;
               var_speed_ff <= add_sat(var_speed_ff, 32'(proc_speed_ff));
               var_yaw_ff   <= add_sat(var_yaw_ff, 32'(proc_yaw_ff));
               state_ff     <= ST_FIN;
            end
            ST_U0: begin
               y0_ff <= sat34({{2{in_ff.enc_speed[31]}}, in_ff.enc_speed}
                              - {{2{speed_ff[31]}}, speed_ff});
               y1_ff <= sat34({{2{in_ff.enc_yaw_rate[31]}}, in_ff.enc_yaw_rate}
                              - {{2{yaw_rate_ff[31]}}, yaw_rate_ff});
               y2_ff <= sat34({{2{in_ff.gyro_rate[31]}}, in_ff.gyro_rate}
                              - {{2{yaw_rate_ff[31]}}, yaw_rate_ff});
               // variances stay non-negative, so these sums fit in 31 bits
               a_ff <= UVAL_W'(add_sat(var_speed_ff, 32'(meas_speed_ff)));
               b_ff <= UVAL_W'(add_sat(var_yaw_ff, 32'(meas_yaw_ff)));
               c_ff <= UVAL_W'(add_sat(var_yaw_ff, 32'(meas_gyro_ff)));
               state_ff <= ST_U1;
            end
            ST_U1: state_ff <= ST_U2;
            ST_U2: begin
               bc_ff    <= prod_ff[PROD_W-1:0];
               state_ff <= ST_U3;
            end
            ST_U3: begin
               cof_ff   <= bc_ff - prod_ff[PROD_W-1:0];
               state_ff <= ST_U4;
            end
            ST_U4: state_ff <= ST_U5;
            ST_U5: begin
               det_ff   <= DET_W'(prod_ff[PROD_W-1:0]);
               state_ff <= ST_U6;
            end
            ST_U6: begin
               det_ff   <= det_ff + DET_W'({prod_ff[PROD_W-1:0], {UVAL_W{1'b0}}});
               state_ff <= ST_U7;
            end
            ST_U7: begin
               ac_ff    <= prod_ff[PROD_W-1:0];
               state_ff <= ST_U8;
            end
            ST_U8: begin
               ab_ff  <= prod_ff[PROD_W-1:0];
               sel_ff <= GAIN_SPEED;
               if (det_q == '0) begin
                  sing_ff  <= 1'b1;
                  state_ff <= ST_FIN;
               end else begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  state_ff <= ST_K0;
               end
            end
            ST_K0: begin
               k_ff     <= qp;
               state_ff <= ST_K1;
            end
            ST_K1: state_ff <= ST_K2;
            ST_K2: begin
               if (sel_ff == GAIN_SPEED) begin
                  speed_ff <= add_sat(speed_ff, qp);
               end else begin
                  yaw_rate_ff <= add_sat(yaw_rate_ff, qp);
               end
               if (sel_ff == GAIN_GYRO) begin
                  state_ff <= ST_FIN;
               end else begin
                  sel_ff   <= sel_ff + 2'd1;
                  state_ff <= ST_DIV;
               end
            end
            ST_FIN: begin
               if (rsp_load) begin
                  out_ff.pos_x_out    <= pos_x_ff;
                  out_ff.heading_out  <= heading_ff;
                  out_ff.speed_out    <= speed_ff;
                  out_ff.yaw_rate_out <= yaw_rate_ff;
                  out_ff.singular     <= sing_ff;
                  state_ff            <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside its wait state");

   a_var_nonneg: assert property (@(posedge clock) disable iff (reset)
      !var_speed_ff[31] && !var_yaw_ff[31])
      else $error("variance went negative");

   a_req_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ST_IDLE)
      else $error("request transaction did not start the sequencer");

endmodule

`default_nettype wire

// ===== sv/ksyf_mul.sv =====
// shared signed 33x33 multiplier with registered product
`default_nettype none

module ksyf_mul import ksyf_pkg::*; (
   input  wire                           clock,
   input  wire  signed [OPD_W-1:0]       op_a,
   input  wire  signed [OPD_W-1:0]       op_b,
   output logic signed [PROD_FULL_W-1:0] prod_ff
);

   logic signed [PROD_FULL_W-1:0] prod_in;

   assign prod_in = PROD_FULL_W'(op_a) * PROD_FULL_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

// ===== sv/ksyf_div.sv =====
// bit-serial restoring divider: floor(num * 2^frac / den), saturated to 31 ones
`default_nettype none

module ksyf_div import ksyf_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start,
   input  wire  [PROD_W-1:0]             num,
   input  wire  [DET_W-FRAC_BITS-1:0]    den,
   output logic                          done_ff,
   output logic [QUOT_W-1:0]             quot_ff
);

   localparam int NW = PROD_W + FRAC_BITS;
   localparam int TW = DET_W - FRAC_BITS + QUOT_W;
   localparam int CW = (NW > TW) ? NW : TW;
   localparam int BW = $clog2(QUOT_W + 1);

   logic [CW-1:0] n_ff;
   logic [CW-1:0] t_ff;
   logic [BW-1:0] bit_ff;
   logic          busy_ff;
   logic          ge;

   assign ge = (n_ff >= t_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            n_ff    <= CW'({num, {FRAC_BITS{1'b0}}});
            t_ff    <= CW'({den, {QUOT_W{1'b0}}});
            bit_ff  <= BW'(QUOT_W);
            quot_ff <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (bit_ff == BW'(QUOT_W)) begin
               // quotient would not fit in 31 bits
               if (ge) begin
                  quot_ff <= '1;
                  busy_ff <= 1'b0;
                  done_ff <= 1'b1;
               end else begin
                  t_ff   <= t_ff >> 1;
                  bit_ff <= bit_ff - 1'b1;
               end
            end else begin
               if (ge) begin
                  n_ff <= n_ff - t_ff;
               end
               quot_ff <= {quot_ff[QUOT_W-2:0], ge};
               if (bit_ff == '0) begin
                  busy_ff <= 1'b0;
                  done_ff <= 1'b1;
               end else begin
                  t_ff   <= t_ff >> 1;
                  bit_ff <= bit_ff - 1'b1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire
